// ----- rtl/aabb_affine_transform_macros.svh -----
// assertion macros for the box transform checker
// each macro expects signals named clock and reset in the enclosing scope
`ifndef AABB_AFFINE_TRANSFORM_MACROS_SVH
`define AABB_AFFINE_TRANSFORM_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define AAT_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("box transform check failed");

// consequent must hold in the cycle after the antecedent
`define AAT_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("box transform check failed");

`endif

// ----- rtl/aat_pkg.sv -----
// shared types and constants of the box transform block
// no dependencies
`default_nettype none

package aat_pkg;

   localparam int DATA_W = 32;
   localparam int REG_W  = 64;

   localparam int NUM_REGS = 6;
   localparam int IDX_W    = 3;

   localparam logic [IDX_W-1:0] REG_ROW_X_A = 3'd0;
   localparam logic [IDX_W-1:0] REG_ROW_X_B = 3'd1;
   localparam logic [IDX_W-1:0] REG_ROW_Y_A = 3'd2;
   localparam logic [IDX_W-1:0] REG_ROW_Y_B = 3'd3;
   localparam logic [IDX_W-1:0] REG_ROW_Z_A = 3'd4;
   localparam logic [IDX_W-1:0] REG_ROW_Z_B = 3'd5;

   // no translation; y and z rows are identity, but the x row diagonal is 32'h1 (one lsb), not 1.0
   localparam logic [REG_W-1:0] RST_ROW_X_A = 64'h0000_0001_0000_0000;
   localparam logic [REG_W-1:0] RST_ROW_X_B = 64'h0000_0000_0000_0000;
   localparam logic [REG_W-1:0] RST_ROW_Y_A = 64'h0000_0000_0001_0000;
   localparam logic [REG_W-1:0] RST_ROW_Y_B = 64'h0000_0000_0000_0000;
   localparam logic [REG_W-1:0] RST_ROW_Z_A = 64'h0000_0000_0000_0000;
   localparam logic [REG_W-1:0] RST_ROW_Z_B = 64'h0001_0000_0000_0000;

   typedef struct packed {
      logic signed [DATA_W-1:0] in_min_x;
      logic signed [DATA_W-1:0] in_min_y;
      logic signed [DATA_W-1:0] in_min_z;
      logic signed [DATA_W-1:0] in_max_x;
      logic signed [DATA_W-1:0] in_max_y;
      logic signed [DATA_W-1:0] in_max_z;
   } aat_req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] out_min_x;
      logic signed [DATA_W-1:0] out_min_y;
      logic signed [DATA_W-1:0] out_min_z;
      logic signed [DATA_W-1:0] out_max_x;
      logic signed [DATA_W-1:0] out_max_y;
      logic signed [DATA_W-1:0] out_max_z;
   } aat_rsp_type;

   // load enables of the datapath stages after the input register
   typedef struct packed {
      logic s2;
      logic s3;
      logic s4;
   } aat_adv_type;

endpackage

`default_nettype wire

// ----- rtl/aat_axis.sv -----
// one output axis of the box transform: products, min/max pick, sum, saturation
// depends on aat_pkg for the stage enable struct
`default_nettype none

module aat_axis
   import aat_pkg::*;
#(
   parameter int CW = 32,
   parameter int F  = 16
) (
   input  logic               clock,
   input  aat_adv_type        adv,
   input  logic [2:0][CW-1:0] lo_i,
   input  logic [2:0][CW-1:0] hi_i,
   input  logic [2:0][CW-1:0] m_i,
   input  logic [CW-1:0]      t_i,
   output logic [CW-1:0]      min_o,
   output logic [CW-1:0]      max_o
);

   localparam int PW = 2 * CW;
   localparam int RW = PW - F;
   localparam int AW = (RW > CW) ? RW : CW;
   localparam int SW = AW + 2;

   localparam logic [PW-1:0] RND_BIAS = (PW'(1) << F) - PW'(1);
   localparam logic signed [SW-1:0] SAT_HI = {{(SW-CW+1){1'b0}}, {(CW-1){1'b1}}};
   localparam logic signed [SW-1:0] SAT_LO = {{(SW-CW+1){1'b1}}, {(CW-1){1'b0}}};

   logic signed [PW-1:0] prod_lo_ff [3];
   logic signed [PW-1:0] prod_lo_in [3];
   logic signed [PW-1:0] prod_hi_ff [3];
   logic signed [PW-1:0] prod_hi_in [3];
   logic signed [CW-1:0] t2_ff;

   logic signed [RW-1:0] rnd_lo [3];
   logic signed [RW-1:0] rnd_hi [3];
   logic signed [RW-1:0] sel_min_ff [3];
   logic signed [RW-1:0] sel_min_in [3];
   logic signed [RW-1:0] sel_max_ff [3];
   logic signed [RW-1:0] sel_max_in [3];
   logic signed [CW-1:0] t3_ff;

   logic signed [SW-1:0] sum_min;
   logic signed [SW-1:0] sum_max;
   logic [CW-1:0]        min_ff;
   logic [CW-1:0]        min_in;
   logic [CW-1:0]        max_ff;
   logic [CW-1:0]        max_in;

   // shift right with rounding toward zero
   function automatic logic signed [RW-1:0] trunc_q(input logic signed [PW-1:0] p);
      logic [PW-1:0] b;
      b = p + (p[PW-1] ? RND_BIAS : '0);
      return b[PW-1:F];
   endfunction

   function automatic logic [CW-1:0] sat_q(input logic signed [SW-1:0] v);
      logic signed [SW-1:0] s;
      if (v > SAT_HI) begin
         s = SAT_HI;
      end else if (v < SAT_LO) begin
         s = SAT_LO;
      end else begin
         s = v;
      end
      return s[CW-1:0];
   endfunction

   // each term is monotonic in its coordinate, so the corner extremes
   // split into independent per-term picks
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         prod_lo_in[k] = $signed(m_i[k]) * $signed(lo_i[k]);
         prod_hi_in[k] = $signed(m_i[k]) * $signed(hi_i[k]);
         rnd_lo[k]     = trunc_q(prod_lo_ff[k]);
         rnd_hi[k]     = trunc_q(prod_hi_ff[k]);
         sel_min_in[k] = (rnd_lo[k] < rnd_hi[k]) ? rnd_lo[k] : rnd_hi[k];
         sel_max_in[k] = (rnd_lo[k] < rnd_hi[k]) ? rnd_hi[k] : rnd_lo[k];
      end
      sum_min = SW'(sel_min_ff[0]) + SW'(sel_min_ff[1]) + SW'(sel_min_ff[2]) + SW'(t3_ff);
      sum_max = SW'(sel_max_ff[0]) + SW'(sel_max_ff[1]) + SW'(sel_max_ff[2]) + SW'(t3_ff);
      min_in  = sat_q(sum_min);
      max_in  = sat_q(sum_max);
   end

   always_ff @(posedge clock) begin
      if (adv.s2) begin
         for (int k = 0; k < 3; k++) begin
            prod_lo_ff[k] <= prod_lo_in[k];
            prod_hi_ff[k] <= prod_hi_in[k];
         end
         t2_ff <= $signed(t_i);
      end
      if (adv.s3) begin
         for (int k = 0; k < 3; k++) begin
            sel_min_ff[k] <= sel_min_in[k];
            sel_max_ff[k] <= sel_max_in[k];
         end
         t3_ff <= t2_ff;
      end
      if (adv.s4) begin
         min_ff <= min_in;
         max_ff <= max_in;
      end
   end

   assign min_o = min_ff;
   assign max_o = max_ff;

endmodule

`default_nettype wire

// ----- rtl/aabb_affine_transform.sv -----
// Box transform by an affine matrix (per-term minimum/maximum method), one box
// per clock while the result side does not stall. An accepted box word passes
// an input register, a product register fed by eighteen parallel multipliers
// (a matrix entry times the minimum and the maximum coordinate on each axis),
// a register holding the per-term minimum and maximum picks, and the result
// register after the sums and saturation, whose valid bit drives rsp_valid.
// Each stage moves whenever the one after it is free, so boxes keep entering
// while a result waits until all four stages hold a box; from then req_stall
// follows rsp_stall in the same cycle. The user must write the matrix
// registers through the csr port only while no box is in flight; the block
// itself does not enforce this.
// depends on aat_pkg and aat_axis
`default_nettype none

module aabb_affine_transform
   import aat_pkg::*;
#(
   parameter int COORD_WIDTH = 32,
   parameter int FRAC_BITS   = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  aat_req_type       req_word,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output aat_rsp_type       rsp_word,
   input  logic              csr_we,
   input  logic [IDX_W-1:0]  csr_index,
   input  logic [REG_W-1:0]  csr_wdata
);

   localparam int CW = COORD_WIDTH;
   localparam int HB = DATA_W;

   logic [REG_W-1:0] row_a_ff [3];
   logic [REG_W-1:0] row_a_in [3];
   logic [REG_W-1:0] row_b_ff [3];
   logic [REG_W-1:0] row_b_in [3];

   aat_req_type req_ff;
   logic        v1_ff, v1_in;
   logic        v2_ff, v2_in;
   logic        v3_ff, v3_in;
   logic        v4_ff, v4_in;
   logic        rdy1, rdy2, rdy3, rdy4;
   aat_adv_type adv;

   logic [2:0][CW-1:0] lo_c;
   logic [2:0][CW-1:0] hi_c;
   logic [2:0][CW-1:0] min_c;
   logic [2:0][CW-1:0] max_c;

   // matrix registers
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         row_a_in[a] = row_a_ff[a];
         row_b_in[a] = row_b_ff[a];
      end
      if (csr_we) begin
         case (csr_index)
            REG_ROW_X_A: row_a_in[0] = csr_wdata;
            REG_ROW_X_B: row_b_in[0] = csr_wdata;
            REG_ROW_Y_A: row_a_in[1] = csr_wdata;
            REG_ROW_Y_B: row_b_in[1] = csr_wdata;
            REG_ROW_Z_A: row_a_in[2] = csr_wdata;
            REG_ROW_Z_B: row_b_in[2] = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_a_ff[0] <= RST_ROW_X_A;
         row_b_ff[0] <= RST_ROW_X_B;
         row_a_ff[1] <= RST_ROW_Y_A;
         row_b_ff[1] <= RST_ROW_Y_B;
         row_a_ff[2] <= RST_ROW_Z_A;
         row_b_ff[2] <= RST_ROW_Z_B;
      end else begin
         for (int a = 0; a < 3; a++) begin
            row_a_ff[a] <= row_a_in[a];
            row_b_ff[a] <= row_b_in[a];
         end
      end
   end

   // stage flow control
   always_comb begin
      rdy4   = !v4_ff || !rsp_stall;
      rdy3   = !v3_ff || rdy4;
      rdy2   = !v2_ff || rdy3;
      rdy1   = !v1_ff || rdy2;
      adv.s2 = v1_ff && rdy2;
      adv.s3 = v2_ff && rdy3;
      adv.s4 = v3_ff && rdy4;
      v1_in  = rdy1 ? req_valid : v1_ff;
      v2_in  = rdy2 ? v1_ff : v2_ff;
      v3_in  = rdy3 ? v2_ff : v3_ff;
      v4_in  = rdy4 ? v3_ff : v4_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && rdy1) begin
         req_ff <= req_word;
      end
   end

   assign req_stall = !rdy1;
   assign rsp_valid = v4_ff;

   always_comb begin
      lo_c[0] = req_ff.in_min_x[CW-1:0];
      lo_c[1] = req_ff.in_min_y[CW-1:0];
      lo_c[2] = req_ff.in_min_z[CW-1:0];
      hi_c[0] = req_ff.in_max_x[CW-1:0];
      hi_c[1] = req_ff.in_max_y[CW-1:0];
      hi_c[2] = req_ff.in_max_z[CW-1:0];
   end

   for (genvar g = 0; g < 3; g++) begin : g_axis
      logic [2:0][CW-1:0] m_row;

      assign m_row[0] = row_a_ff[g][HB+CW-1:HB];
      assign m_row[1] = row_a_ff[g][CW-1:0];
      assign m_row[2] = row_b_ff[g][HB+CW-1:HB];

      aat_axis #(
         .CW (CW),
         .F  (FRAC_BITS)
      ) u_axis (
         .clock (clock),
         .adv   (adv),
         .lo_i  (lo_c),
         .hi_i  (hi_c),
         .m_i   (m_row),
         .t_i   (row_b_ff[g][CW-1:0]),
         .min_o (min_c[g]),
         .max_o (max_c[g])
      );
   end

   always_comb begin
      rsp_word.out_min_x = DATA_W'($signed(min_c[0]));
      rsp_word.out_min_y = DATA_W'($signed(min_c[1]));
      rsp_word.out_min_z = DATA_W'($signed(min_c[2]));
      rsp_word.out_max_x = DATA_W'($signed(max_c[0]));
      rsp_word.out_max_y = DATA_W'($signed(max_c[1]));
      rsp_word.out_max_z = DATA_W'($signed(max_c[2]));
   end

endmodule

`default_nettype wire

// ----- rtl/aat_checker.sv -----
// port-level checks of the box transform, bound to the top level
// depends on aat_pkg and aabb_affine_transform_macros.svh
`default_nettype none

`include "aabb_affine_transform_macros.svh"

module aat_checker
   import aat_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire aat_rsp_type rsp_word
);

   // a stalled result word stays put
   `AAT_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_word))

   // the input side only stalls when the result side does
   `AAT_ASSERT_NOW(a_stall_source, !rsp_stall, !req_stall)

   // an accepted word comes out when the result side does not stall while it passes the stages
   `AAT_ASSERT_NEXT(a_latency, (req_valid && !req_stall) ##1 !rsp_stall ##1 !rsp_stall ##1 !rsp_stall, rsp_valid)

   // the transformed box is never inverted
   `AAT_ASSERT_NOW(a_box_order, rsp_valid, (rsp_word.out_min_x <= rsp_word.out_max_x) && (rsp_word.out_min_y <= rsp_word.out_max_y) && (rsp_word.out_min_z <= rsp_word.out_max_z))

endmodule

bind aabb_affine_transform aat_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_word  (rsp_word)
);

`default_nettype wire

// ----- sim/tb_aabb_affine_transform.sv -----
// self-checking testbench for aabb_affine_transform: boxes are predicted in
// the bench and compared with each result word, under random idling on both sides
// depends on aat_pkg and the aabb_affine_transform rtl
`default_nettype none

module tb_aabb_affine_transform;
   import aat_pkg::*;

   localparam int FRAC = 16;
   localparam int STALL_LIMIT = 5000;
   localparam int RANDOM_PHASES = 10;
   localparam int BOXES_PER_PHASE = 103;

   localparam logic [IDX_W-1:0] REG_SPARE_6 = 3'd6;
   localparam logic [IDX_W-1:0] REG_SPARE_7 = 3'd7;

   localparam logic signed [DATA_W-1:0] Q_ZERO    = 32'h0000_0000;
   localparam logic signed [DATA_W-1:0] Q_ONE     = 32'h0001_0000;
   localparam logic signed [DATA_W-1:0] Q_NEG_ONE = 32'hffff_0000;
   localparam logic signed [DATA_W-1:0] Q_MAX     = 32'h7fff_ffff;
   localparam logic signed [DATA_W-1:0] Q_MIN     = 32'h8000_0000;
   localparam logic signed [DATA_W-1:0] Q_LSB     = 32'h0000_0001;
   localparam logic signed [DATA_W-1:0] Q_NEG_LSB = 32'hffff_ffff;

   localparam longint SAT_HI = 64'sd2147483647;
   localparam longint SAT_LO = -64'sd2147483648;

   typedef enum int {VAL_SMALL, VAL_FULL, VAL_EDGE} value_class_e;
   typedef enum int {MAT_SMALL, MAT_FULL, MAT_EDGE, MAT_MIXED} matrix_mode_e;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   aat_req_type       req_word;
   logic              rsp_valid;
   logic              rsp_stall;
   aat_rsp_type       rsp_word;
   logic              csr_we;
   logic [IDX_W-1:0]  csr_index;
   logic [REG_W-1:0]  csr_wdata;

   logic [REG_W-1:0]  row_shadow [NUM_REGS];
   logic [IDX_W-1:0]  row_index [NUM_REGS] = '{REG_ROW_X_A, REG_ROW_X_B, REG_ROW_Y_A,
                                               REG_ROW_Y_B, REG_ROW_Z_A, REG_ROW_Z_B};
   string             field_name [6] = '{"max_z", "max_y", "max_x",
                                         "min_z", "min_y", "min_x"};

   aat_rsp_type       expected_boxes [$];
   bit                quiet = 0;
   int                error_count = 0;
   int                boxes_sent = 0;
   int                boxes_checked = 0;
   int                matrix_loads = 0;
   int                idle_cycles = 0;

   aabb_affine_transform dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------- predictor ----------------

   function automatic longint fx_term(logic signed [DATA_W-1:0] m,
                                      logic signed [DATA_W-1:0] c);
      longint p;
      p = longint'(m) * longint'(c);
      if (p < 0) return -((-p) >> FRAC);
      return p >> FRAC;
   endfunction

   function automatic logic signed [DATA_W-1:0] sat32(longint v);
      if (v > SAT_HI) return Q_MAX;
      if (v < SAT_LO) return Q_MIN;
      return v[DATA_W-1:0];
   endfunction

   function automatic aat_rsp_type transform_box(aat_req_type b);
      logic signed [DATA_W-1:0] lo [3];
      logic signed [DATA_W-1:0] hi [3];
      logic signed [DATA_W-1:0] m [3][3];
      logic signed [DATA_W-1:0] tr [3];
      logic signed [DATA_W-1:0] pt [3];
      logic signed [DATA_W-1:0] mn [3];
      logic signed [DATA_W-1:0] mx [3];
      logic signed [DATA_W-1:0] s;
      longint acc;
      aat_rsp_type r;
      lo = '{b.in_min_x, b.in_min_y, b.in_min_z};
      hi = '{b.in_max_x, b.in_max_y, b.in_max_z};
      for (int a = 0; a < 3; a++) begin
         m[a][0] = row_shadow[2*a][63:32];
         m[a][1] = row_shadow[2*a][31:0];
         m[a][2] = row_shadow[2*a+1][63:32];
         tr[a]   = row_shadow[2*a+1][31:0];
      end
      for (int c = 0; c < 8; c++) begin
         pt[0] = ((c & 1) != 0) ? hi[0] : lo[0];
         pt[1] = ((c & 2) != 0) ? hi[1] : lo[1];
         pt[2] = ((c & 4) != 0) ? hi[2] : lo[2];
         for (int a = 0; a < 3; a++) begin
            acc = longint'(tr[a]);
            for (int k = 0; k < 3; k++) acc += fx_term(m[a][k], pt[k]);
            s = sat32(acc);
            if (c == 0 || s < mn[a]) mn[a] = s;
            if (c == 0 || s > mx[a]) mx[a] = s;
         end
      end
      r = '{mn[0], mn[1], mn[2], mx[0], mx[1], mx[2]};
      return r;
   endfunction

   // ---------------- stimulus helpers ----------------

   function automatic logic signed [DATA_W-1:0] pick_value(value_class_e vc, int unsigned span);
      case (vc)
         VAL_FULL: return $urandom;
         VAL_SMALL: return $urandom_range(0, 2 * span) - span;
         default: begin
            case ($urandom_range(0, 6))
               0: return Q_MIN;
               1: return Q_MAX;
               2: return Q_ZERO;
               3: return Q_NEG_LSB;
               4: return Q_LSB;
               5: return Q_ONE;
               default: return Q_NEG_ONE;
            endcase
         end
      endcase
   endfunction

   function automatic value_class_e random_class();
      case ($urandom_range(0, 3))
         0, 1: return VAL_SMALL;
         2: return VAL_FULL;
         default: return VAL_EDGE;
      endcase
   endfunction

   function automatic aat_req_type box_of(logic signed [DATA_W-1:0] nx, ny, nz, px, py, pz);
      aat_req_type b;
      b = '{nx, ny, nz, px, py, pz};
      return b;
   endfunction

   // mostly well-ordered boxes, some left as drawn; force_inverted puts min at or above max on every axis
   function automatic aat_req_type random_box(bit force_inverted);
      logic signed [DATA_W-1:0] lo [3];
      logic signed [DATA_W-1:0] hi [3];
      logic signed [DATA_W-1:0] t;
      bit ordered;
      ordered = ($urandom_range(0, 99) < 85);
      for (int a = 0; a < 3; a++) begin
         lo[a] = pick_value(random_class(), 64 << FRAC);
         hi[a] = pick_value(random_class(), 64 << FRAC);
         if ((force_inverted && lo[a] < hi[a]) || (!force_inverted && ordered && lo[a] > hi[a]))
         begin
            t = lo[a];
            lo[a] = hi[a];
            hi[a] = t;
         end
      end
      return box_of(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
   endfunction

   task automatic csr_write(input logic [IDX_W-1:0] idx, input logic [REG_W-1:0] data);
      @(negedge clock);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(posedge clock);
      if (idx < NUM_REGS) row_shadow[idx] = data;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic load_random_matrix(matrix_mode_e mode);
      logic signed [DATA_W-1:0] hi, lo;
      value_class_e vc;
      for (int i = 0; i < NUM_REGS; i++) begin
         case (mode)
            MAT_SMALL: vc = VAL_SMALL;
            MAT_FULL:  vc = VAL_FULL;
            MAT_EDGE:  vc = VAL_EDGE;
            default:   vc = random_class();
         endcase
         hi = pick_value(vc, 4 << FRAC);
         // odd registers carry the translation in the low half
         lo = pick_value(mode == MAT_MIXED ? random_class() : vc,
                         (i % 2 == 1) ? (256 << FRAC) : (4 << FRAC));
         csr_write(row_index[i], {hi, lo});
      end
      matrix_loads++;
   endtask

   task automatic send_box(aat_req_type b);
      @(negedge clock);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 10)) @(negedge clock);
      end
      req_valid = 1'b1;
      req_word = b;
      do @(posedge clock); while (req_stall);
      expected_boxes.push_back(transform_box(b));
      boxes_sent++;
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (expected_boxes.size() != 0) @(posedge clock);
   endtask

   // ---------------- tests ----------------

   task automatic test_reset_identity();
      send_box(box_of(Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO));
      send_box(box_of(Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX));
      send_box(box_of(32'h0005_0000, 32'h0005_0000, 32'h0005_0000,
                      32'hfffd_0000, 32'hfffd_0000, 32'hfffd_0000));
      send_box(box_of(32'h0001_8000, 32'h0001_8000, 32'h0001_8000,
                      32'h0001_8000, 32'h0001_8000, 32'h0001_8000));
      send_box(box_of(Q_NEG_LSB, Q_NEG_LSB, Q_NEG_LSB, Q_LSB, Q_LSB, Q_LSB));
      send_box(random_box(1'b0));
   endtask

   task automatic test_extreme_matrix();
      drain();
      csr_write(REG_ROW_X_A, {Q_MAX, Q_MAX});
      csr_write(REG_ROW_X_B, {Q_MAX, Q_MAX});
      csr_write(REG_ROW_Y_A, {Q_MIN, Q_MIN});
      csr_write(REG_ROW_Y_B, {Q_MIN, Q_MIN});
      csr_write(REG_ROW_Z_A, {Q_MAX, Q_MIN});
      csr_write(REG_ROW_Z_B, {Q_NEG_LSB, Q_ZERO});
      matrix_loads++;
      send_box(box_of(Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO));
      send_box(box_of(Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX));
      send_box(box_of(Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN));
      send_box(box_of(Q_NEG_ONE, Q_NEG_ONE, Q_NEG_ONE, Q_ONE, Q_ONE, Q_ONE));
      send_box(box_of(Q_NEG_LSB, Q_NEG_LSB, Q_NEG_LSB, Q_LSB, Q_LSB, Q_LSB));
      send_box(box_of(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN));
      send_box(box_of(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX));
      send_box(random_box(1'b0));
   endtask

   task automatic test_unknown_index();
      drain();
      load_random_matrix(MAT_SMALL);
      csr_write(REG_SPARE_6, {$urandom, $urandom});
      csr_write(REG_SPARE_7, {$urandom, $urandom});
      repeat (3) send_box(random_box(1'b0));
   endtask

   task automatic test_inverted_box();
      drain();
      load_random_matrix(MAT_SMALL);
      repeat (5) send_box(random_box(1'b1));
   endtask

   task automatic test_random_boxes();
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         drain();
         if (p == RANDOM_PHASES - 1) quiet = 1;
         load_random_matrix(matrix_mode_e'(p % 4));
         for (int i = 0; i < BOXES_PER_PHASE; i++) begin
            // hold off mid-phase until the pipeline is empty
            if (i == BOXES_PER_PHASE / 2 && p % 3 == 0) drain();
            send_box(random_box(1'b0));
         end
      end
   endtask

   // ---------------- result side ----------------

   initial begin
      int unsigned burst;
      burst = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (burst != 0) begin
            rsp_stall = 1'b1;
            burst--;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            rsp_stall = 1'b1;
            burst = $urandom_range(1, 10) - 1;
         end else begin
            rsp_stall = 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      logic [5:0][DATA_W-1:0] got_f, want_f;
      aat_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_boxes.size() == 0) begin
            if (error_count < 10) $display("unexpected result word %h", rsp_word);
            error_count++;
         end else begin
            want = expected_boxes.pop_front();
            got_f = rsp_word;
            want_f = want;
            for (int f = 5; f >= 0; f--) begin
               if (got_f[f] !== want_f[f]) begin
                  if (error_count < 10)
                     $display("result %0d out_%s: expected %h, got %h",
                              boxes_checked, field_name[f], want_f[f], got_f[f]);
                  error_count++;
               end
            end
            boxes_checked++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("no word moved for %0d cycles", STALL_LIMIT);
         $display("tb_aabb_affine_transform: FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------- sequence ----------------

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_word = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      row_shadow = '{RST_ROW_X_A, RST_ROW_X_B, RST_ROW_Y_A,
                     RST_ROW_Y_B, RST_ROW_Z_A, RST_ROW_Z_B};
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_identity();
      test_extreme_matrix();
      test_unknown_index();
      test_inverted_box();
      test_random_boxes();

      drain();
      repeat (10) @(posedge clock);
      if (expected_boxes.size() != 0) begin
         $display("%0d results never arrived", expected_boxes.size());
         error_count++;
      end

      $display("sent %0d boxes over %0d matrix loads plus the reset identity", boxes_sent,
               matrix_loads);
      $display("checked %0d result words, %0d errors", boxes_checked, error_count);
      if (error_count == 0) begin
         $display("tb_aabb_affine_transform: PASS");
      end else begin
         $display("tb_aabb_affine_transform: FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ----- files.f -----
+incdir+rtl
rtl/aat_pkg.sv
rtl/aat_axis.sv
rtl/aabb_affine_transform.sv
rtl/aat_checker.sv
sim/tb_aabb_affine_transform.sv
